// ===== hw/rtl/bbc_pkg.sv =====
`default_nettype none

package bbc_pkg;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int CNT_W   = 8;
    localparam int TICK_W  = 32;
    localparam int HDL_W   = 5;
    localparam int RES_W   = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One entry of the tag store
    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  cnt;
        logic [TICK_W-1:0] lu;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

`default_nettype wire

// ===== hw/rtl/block_buffer_cache_lru_core.sv =====
`default_nettype none

// Tag store of a disk block buffer cache with timestamp LRU replacement.
// Requests arrive on the slave stream: tuser holds the operation (get,
// release, pin, unpin), tdata the device, block, buffer handle and tick.
// Every request gives exactly one result on the master stream: buffer
// index, hit flag, need-read flag and status (1 = no free buffer).
// One request is handled at a time. A get reads all NUM_BUFFERS entries
// through the single read port of the tag RAM, one per cycle, then drains
// the last read and writes back while the result is staged.
// Release, pin and unpin do one read and one write; a handle outside the
// buffer range changes nothing. The next request is taken once the staged
// result has moved into the output register.
// The result sits in an output register; a stalled receiver holds it and
// the block takes the next request meanwhile, waiting only to hand over
// the following result.
// Reset clears all entries at once (per-entry valid bits): every buffer
// is free, untagged, with count and last-use tick zero.
module block_buffer_cache_lru_core #(
    parameter int NUM_BUFFERS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // device[7:0], block_number[39:8], buffer_index[44:40], now_tick[76:45]
    input  wire logic [79:0] i_s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // result_index[4:0], was_hit[5], need_read[6], status[7]
    output logic [7:0]       o_m_axis_tdata
);

    localparam int IDX_W = $clog2(NUM_BUFFERS);
    localparam int HDL_W = bbc_pkg::HDL_W;
    localparam int RES_W = bbc_pkg::RES_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_UPD   = 7'b0001000,
        S_ORD   = 7'b0010000,
        S_OWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                          r_state;
    bbc_pkg::t_op                    r_req_op;
    logic [bbc_pkg::DEV_W-1:0]       r_req_dev;
    logic [bbc_pkg::BLK_W-1:0]       r_req_blk;
    logic [HDL_W-1:0]                r_req_hdl;
    logic [bbc_pkg::TICK_W-1:0]      r_req_tick;
    logic [IDX_W-1:0]                r_addr;
    logic                            r_pend;
    logic [IDX_W-1:0]                r_pidx;
    logic [NUM_BUFFERS-1:0]          r_tagged;
    logic [RES_W-1:0]                r_res;
    logic                            r_o_valid;
    logic [RES_W-1:0]                r_o_data;

    logic                            w_accept;
    logic [IDX_W-1:0]                w_hdl_idx;
    logic                            w_rd_en;
    logic [IDX_W-1:0]                w_rd_addr;
    bbc_pkg::t_rec                   w_rd_rec;
    logic                            w_wr_en;
    logic [IDX_W-1:0]                w_wr_addr;
    bbc_pkg::t_rec                   w_wr_rec;
    logic                            w_hit;
    logic [IDX_W-1:0]                w_hit_idx;
    bbc_pkg::t_rec                   w_hit_rec;
    logic                            w_found;
    logic [IDX_W-1:0]                w_pick_idx;
    logic [bbc_pkg::TICK_W-1:0]      w_pick_lu;
    logic [bbc_pkg::CNT_W-1:0]       w_op_cnt;
    logic [bbc_pkg::TICK_W-1:0]      w_op_lu;
    logic                            w_out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_hdl_idx       = IDX_W'(r_req_hdl);
    assign w_out_free      = !r_o_valid || i_m_axis_tready;

    // Read address: scan counter during a get, the handle otherwise
    assign w_rd_en   = (r_state == S_SCAN) || (r_state == S_ORD);
    assign w_rd_addr = (r_state == S_SCAN) ? r_addr : w_hdl_idx;

    // New count and tick for release, pin and unpin
    always_comb begin
        w_op_cnt = w_rd_rec.cnt;
        w_op_lu  = w_rd_rec.lu;
        case (r_req_op)
            bbc_pkg::OP_RELEASE: begin
                if (w_rd_rec.cnt != '0) begin
                    w_op_cnt = w_rd_rec.cnt - 1'b1;
                    if (w_rd_rec.cnt == bbc_pkg::CNT_W'(1)) begin
                        w_op_lu = r_req_tick;
                    end
                end
            end
            bbc_pkg::OP_PIN: begin
                if (w_rd_rec.cnt != bbc_pkg::CNT_MAX) begin
                    w_op_cnt = w_rd_rec.cnt + 1'b1;
                end
            end
            bbc_pkg::OP_UNPIN: begin
                if (w_rd_rec.cnt != '0) begin
                    w_op_cnt = w_rd_rec.cnt - 1'b1;
                end
            end
            default: begin
                w_op_cnt = w_rd_rec.cnt;
            end
        endcase
    end

    // Write port: hit count update, miss retag, or handle operation
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_hdl_idx;
        w_wr_rec  = w_rd_rec;
        if (r_state == S_UPD) begin
            if (w_hit) begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_hit_idx;
                w_wr_rec  = w_hit_rec;
                if (w_hit_rec.cnt != bbc_pkg::CNT_MAX) begin
                    w_wr_rec.cnt = w_hit_rec.cnt + 1'b1;
                end
            end else if (w_found) begin
                w_wr_en      = 1'b1;
                w_wr_addr    = w_pick_idx;
                w_wr_rec.dev = r_req_dev;
                w_wr_rec.blk = r_req_blk;
                w_wr_rec.cnt = bbc_pkg::CNT_W'(1);
                w_wr_rec.lu  = w_pick_lu;
            end
        end else if (r_state == S_OWR) begin
            w_wr_en      = 1'b1;
            w_wr_rec.cnt = w_op_cnt;
            w_wr_rec.lu  = w_op_lu;
        end
    end

    bbc_tag_ram #(
        .DEPTH (NUM_BUFFERS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_rec  (w_rd_rec),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_rec  (w_wr_rec)
    );

    bbc_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_clear    (w_accept),
        .i_en       (r_pend && (r_state == S_SCAN || r_state == S_DRAIN)),
        .i_idx      (r_pidx),
        .i_rec      (w_rd_rec),
        .i_tagged   (r_tagged[r_pidx]),
        .i_dev      (r_req_dev),
        .i_blk      (r_req_blk),
        .o_hit      (w_hit),
        .o_hit_idx  (w_hit_idx),
        .o_hit_rec  (w_hit_rec),
        .o_found    (w_found),
        .o_pick_idx (w_pick_idx),
        .o_pick_lu  (w_pick_lu)
    );

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_op   <= bbc_pkg::t_op'(i_s_axis_tuser);
            r_req_dev  <= i_s_axis_tdata[7:0];
            r_req_blk  <= i_s_axis_tdata[39:8];
            r_req_hdl  <= i_s_axis_tdata[44:40];
            r_req_tick <= i_s_axis_tdata[76:45];
        end
    end

    // Track which read is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_rd_en;
        end
        if (w_rd_en) begin
            r_pidx <= w_rd_addr;
        end
    end

    // Mark entries tagged on a miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tagged <= '0;
        end else if (r_state == S_UPD && !w_hit && w_found) begin
            r_tagged[w_pick_idx] <= 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr <= '0;
                        r_res  <= '0;
                        if (bbc_pkg::t_op'(i_s_axis_tuser) == bbc_pkg::OP_GET) begin
                            r_state <= S_SCAN;
                        end else if (32'(i_s_axis_tdata[44:40]) < NUM_BUFFERS) begin
                            r_state <= S_ORD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_hit) begin
                        r_res <= {1'b0, 1'b0, 1'b1, HDL_W'(w_hit_idx)};
                    end else if (w_found) begin
                        r_res <= {1'b0, 1'b1, 1'b0, HDL_W'(w_pick_idx)};
                    end else begin
                        r_res <= {1'b1, 1'b0, 1'b0, HDL_W'(0)};
                    end
                    r_state <= S_DONE;
                end
                S_ORD: begin
                    r_state <= S_OWR;
                end
                S_OWR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: load on hand-off, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_o_data <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // The only unused request bits are the tdata pad
    logic w_unused;
    assign w_unused = ^i_s_axis_tdata[79:77];

`ifndef SYNTH
    a_hit_tagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && w_hit) |-> r_tagged[w_hit_idx])
        else $error("hit on an untagged entry");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    a_drain_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_pend)
        else $error("last scan read missing in drain");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_tag_ram.sv =====
`default_nettype none

module bbc_tag_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output bbc_pkg::t_rec        o_rd_rec,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire bbc_pkg::t_rec   i_wr_rec
);

    bbc_pkg::t_rec    mem [DEPTH];
    bbc_pkg::t_rec    r_q;
    logic [AW-1:0]    r_q_addr;
    logic [DEPTH-1:0] r_init;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_rec;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q      <= mem[i_rd_addr];
            r_q_addr <= i_rd_addr;
        end
    end

    // Track entries written since reset; the rest read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_wr_en) begin
            r_init[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_rec = r_init[r_q_addr] ? r_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_scan.sv =====
`default_nettype none

module bbc_scan #(
    parameter int IDX_W = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_clear,
    input  wire logic                        i_en,
    input  wire logic [IDX_W-1:0]            i_idx,
    input  wire bbc_pkg::t_rec               i_rec,
    input  wire logic                        i_tagged,
    input  wire logic [bbc_pkg::DEV_W-1:0]   i_dev,
    input  wire logic [bbc_pkg::BLK_W-1:0]   i_blk,
    output logic                             o_hit,
    output logic [IDX_W-1:0]                 o_hit_idx,
    output bbc_pkg::t_rec                    o_hit_rec,
    output logic                             o_found,
    output logic [IDX_W-1:0]                 o_pick_idx,
    output logic [bbc_pkg::TICK_W-1:0]       o_pick_lu
);

    logic w_match;
    logic w_better;

    assign w_match  = i_tagged && (i_rec.dev == i_dev) && (i_rec.blk == i_blk);
    assign w_better = (i_rec.cnt == '0) && (!o_found || (i_rec.lu < o_pick_lu));

    // Keep the first matching entry and the oldest free entry
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            o_hit   <= 1'b0;
            o_found <= 1'b0;
        end else if (i_en) begin
            if (w_match && !o_hit) begin
                o_hit     <= 1'b1;
                o_hit_idx <= i_idx;
                o_hit_rec <= i_rec;
            end
            if (w_better) begin
                o_found    <= 1'b1;
                o_pick_idx <= i_idx;
                o_pick_lu  <= i_rec.lu;
            end
        end
    end

endmodule

`default_nettype wire
